// ----- src/address_resolution_cache_macros.svh -----
// Assertion macros used by the address resolution cache top level.
`ifndef ADDRESS_RESOLUTION_CACHE_MACROS_SVH
`define ADDRESS_RESOLUTION_CACHE_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define ARC_ASSERT_SAME(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define ARC_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/arc_pkg.sv -----
// Package with widths, codes and types of the address resolution cache.
package arc_pkg;

    localparam int DEF_ENTRIES = 32;
    localparam int IP_W        = 32;
    localparam int MAC_W       = 48;
    localparam int IDX_OUT_W   = 5;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    // search item walking the cell chain
    typedef struct packed {
        logic             valid;
        logic             op;
        logic             hit;
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
        logic [MAC_W-1:0] found;
    } t_token;

    typedef struct packed {
        logic                 hit;
        logic [MAC_W-1:0]     found_mac;
        logic [IDX_OUT_W-1:0] entry_index;
    } t_result;

endpackage

// ----- src/arc_req_if.sv -----
// Request channel interface: operation, address and MAC.
interface arc_req_if import arc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             operation;
    logic [IP_W-1:0]  ip_address;
    logic [MAC_W-1:0] mac_address;

    modport source (output valid, output operation, output ip_address,
                    output mac_address, input ready);
    modport sink   (input valid, input operation, input ip_address,
                    input mac_address, output ready);
endinterface

// ----- src/arc_rsp_if.sv -----
// Response channel interface: hit flag, MAC and entry index.
interface arc_rsp_if import arc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 hit;
    logic [MAC_W-1:0]     found_mac;
    logic [IDX_OUT_W-1:0] entry_index;

    modport source (output valid, output hit, output found_mac,
                    output entry_index, input ready);
    modport sink   (input valid, input hit, input found_mac,
                    input entry_index, output ready);
endinterface

// ----- src/address_resolution_cache.sv -----
// Top level of the address resolution cache: cell chain, insert control and output stage.
//
// Fully associative IPv4 to MAC table with round-robin replacement.
// Request channel i_req carries operation (lookup or update), ip_address
// and mac_address; response channel o_rsp returns hit, found_mac and the
// low five bits of entry_index, one response per request item.
// An accepted item walks the row of ENTRIES cells, one cell per cycle; the
// lowest cell whose address matches captures the hit. When the item leaves
// the last cell, an update that found no match is written at the write
// pointer, which then advances and wraps.
// The item is registered in each cell in turn, the response in the output register.
// Only one item is in the cell chain at a time: the next item is taken after
// the last one leaves the last cell, also while a response waits.
// Reset: per-entry valid bits and the write pointer clear at once, so every
// entry reads as address 0.0.0.0 with MAC 0; no clearing pass is needed.
// Stall: a response waits in the output register, a second one in a
// holding slot; while that slot is full no new item is taken.
`include "address_resolution_cache_macros.svh"
module address_resolution_cache import arc_pkg::*; #(
    parameter int ENTRIES = DEF_ENTRIES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    arc_req_if.sink    i_req,
    arc_rsp_if.source  o_rsp
);

    localparam int IDX_W = $clog2(ENTRIES);

    t_token           tok     [ENTRIES+1];
    logic [IDX_W-1:0] tok_idx [ENTRIES+1];

    logic             r_busy;
    logic [IDX_W-1:0] r_wp;
    logic             r_out_valid;
    t_result          r_out;
    logic             r_pend_valid;
    t_result          r_pend;

    logic                     req_take;
    logic                     out_take;
    t_token                   tail;
    logic                     ins_en;
    logic [IDX_W-1:0]         res_idx;
    logic [IDX_W+IDX_OUT_W-1:0] res_idx_wide;
    t_result                  res;

    // hold requests while a search runs or the holding slot is full
    assign i_req.ready = !r_busy && !r_pend_valid;
    assign req_take    = i_req.valid && i_req.ready;
    assign out_take    = r_out_valid && o_rsp.ready;

    // inject the item at the head of the chain
    always_comb begin
        tok[0]       = '0;
        tok[0].valid = req_take;
        tok[0].op    = i_req.operation;
        tok[0].ip    = i_req.ip_address;
        tok[0].mac   = i_req.mac_address;
        tok_idx[0]   = '0;
    end

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        arc_cell #(
            .IDX_W (IDX_W),
            .INDEX (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_tok     (tok[g]),
            .i_tok_idx (tok_idx[g]),
            .i_ins_en  (ins_en),
            .i_ins_idx (r_wp),
            .i_ins_ip  (tail.ip),
            .i_ins_mac (tail.mac),
            .o_tok     (tok[g+1]),
            .o_tok_idx (tok_idx[g+1])
        );
    end

    assign tail   = tok[ENTRIES];
    // an update that missed everywhere takes the entry at the write pointer
    assign ins_en = tail.valid && (tail.op == OP_UPDATE) && !tail.hit;

    always_comb begin
        res_idx         = ins_en ? r_wp : tok_idx[ENTRIES];
        res_idx_wide    = {{IDX_OUT_W{1'b0}}, res_idx};
        res.hit         = tail.hit;
        res.found_mac   = tail.found;
        res.entry_index = res_idx_wide[IDX_OUT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_wp         <= '0;
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            if (req_take) begin
                r_busy <= 1'b1;
            end else if (tail.valid) begin
                r_busy <= 1'b0;
            end

            // advance the write pointer and wrap at the last entry
            if (ins_en) begin
                r_wp <= (r_wp == IDX_W'(ENTRIES - 1)) ? '0 : r_wp + 1'b1;
            end

            if (tail.valid) begin
                if (!r_out_valid || out_take) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_pend_valid <= 1'b1;
                end
            end else if (out_take) begin
                if (r_pend_valid) begin
                    r_pend_valid <= 1'b0;
                end else begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (tail.valid) begin
            if (!r_out_valid || out_take) begin
                r_out <= res;
            end else begin
                r_pend <= res;
            end
        end else if (out_take && r_pend_valid) begin
            r_out <= r_pend;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.hit         = r_out.hit;
    assign o_rsp.found_mac   = r_out.found_mac;
    assign o_rsp.entry_index = r_out.entry_index;

    `ARC_ASSERT_SAME(a_tail_busy, i_clk, i_rst_n, tail.valid, r_busy, "item left chain while idle")
    `ARC_ASSERT_SAME(a_tail_slot, i_clk, i_rst_n, tail.valid, !r_pend_valid, "no slot for response")
    `ARC_ASSERT_SAME(a_pend_out, i_clk, i_rst_n, r_pend_valid, r_out_valid, "holding slot out of order")
    `ARC_ASSERT_NEXT(a_wp_range, i_clk, i_rst_n, ins_en, r_wp <= IDX_W'(ENTRIES - 1), "write pointer out of range")

endmodule

// ----- src/arc_cell.sv -----
// One table entry of the cache chain: compare, capture and forward the search item.
module arc_cell import arc_pkg::*; #(
    parameter int IDX_W = 5,
    parameter int INDEX = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_token           i_tok,
    input  logic [IDX_W-1:0] i_tok_idx,
    input  logic             i_ins_en,
    input  logic [IDX_W-1:0] i_ins_idx,
    input  logic [IP_W-1:0]  i_ins_ip,
    input  logic [MAC_W-1:0] i_ins_mac,
    output t_token           o_tok,
    output logic [IDX_W-1:0] o_tok_idx
);

    logic             r_valid;
    logic [IP_W-1:0]  r_ip;
    logic [MAC_W-1:0] r_mac;
    t_token           r_tok;
    t_token           n_tok;
    logic [IDX_W-1:0] r_tok_idx;
    logic [IDX_W-1:0] n_tok_idx;

    logic [IP_W-1:0]  eff_ip;
    logic [MAC_W-1:0] eff_mac;
    logic             match;
    logic             ins_here;

    // an entry never written reads as all zeros
    assign eff_ip   = r_valid ? r_ip  : '0;
    assign eff_mac  = r_valid ? r_mac : '0;
    assign match    = i_tok.valid && !i_tok.hit && (eff_ip == i_tok.ip);
    assign ins_here = i_ins_en && (i_ins_idx == IDX_W'(INDEX));

    always_comb begin
        n_tok     = i_tok;
        n_tok_idx = i_tok_idx;
        if (match) begin
            n_tok.hit = 1'b1;
            n_tok_idx = IDX_W'(INDEX);
            n_tok.found = (i_tok.op == OP_LOOKUP) ? eff_mac : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_tok     <= '0;
        end else begin
            r_tok <= n_tok;
            if (ins_here || (match && i_tok.op == OP_UPDATE)) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok_idx <= n_tok_idx;
        if (ins_here) begin
            r_ip  <= i_ins_ip;
            r_mac <= i_ins_mac;
        end else if (match && i_tok.op == OP_UPDATE) begin
            r_ip  <= eff_ip;
            r_mac <= i_tok.mac;
        end
    end

    assign o_tok     = r_tok;
    assign o_tok_idx = r_tok_idx;

endmodule
